// File: src/conv2d_valid_5x5_stream_assert.svh
// assertion macros for the 5x5 convolution stream
`ifndef CONV2D_VALID_5X5_STREAM_ASSERT_SVH
`define CONV2D_VALID_5X5_STREAM_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define C2D_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c2d assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define C2D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c2d assertion failed");

`endif

// File: src/c2d_pkg.sv
// shared types and constants of the 5x5 convolution stream
package c2d_pkg;

    localparam int IMG_HEIGHT  = 28;
    localparam int IMG_WIDTH   = 28;
    localparam int KSIZE       = 5;
    localparam int NLINES      = KSIZE - 1;

    localparam int PIX_W       = 8;
    localparam int COL_W       = $clog2(IMG_WIDTH);
    localparam int ROW_W       = $clog2(IMG_HEIGHT);
    localparam int POS_W       = 5;
    localparam int PROD_W      = 2 * PIX_W;
    localparam int RSUM_W      = PROD_W + $clog2(KSIZE);
    localparam int SUM_W       = 21;
    localparam int KREG_W      = KSIZE * PIX_W;
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_ROW0,
        REG_KERNEL_ROW1,
        REG_KERNEL_ROW2,
        REG_KERNEL_ROW3,
        REG_KERNEL_ROW4
    } cfg_reg_e;

    typedef logic [NLINES-1:0][PIX_W-1:0]            line_word_t;
    typedef logic [KSIZE-1:0][PIX_W-1:0]             column_t;
    typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0]  window_t;

    typedef struct packed {
        logic adv;
        logic load;
        logic s1_valid;
    } pipe_ctl_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
    } pixel_item_t;

    typedef struct packed {
        logic [SUM_W-1:0] conv_sum;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             last_of_frame;
    } result_item_t;

    typedef struct packed {
        logic             emit;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } pos_meta_t;

endpackage

// File: src/c2d_stream_if.sv
// valid/ready channels for pixel items and result items
interface c2d_pixel_if;
    logic                 valid;
    logic                 ready;
    c2d_pkg::pixel_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface c2d_result_if;
    logic                  valid;
    logic                  ready;
    c2d_pkg::result_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/c2d_line_buf.sv
// four line buffers in one memory, one column word per address
module c2d_line_buf (
    input  logic                           clk,
    input  c2d_pkg::pipe_ctl_t             ctl,
    input  logic [c2d_pkg::PIX_W-1:0]      pixel,
    input  logic [c2d_pkg::COL_W-1:0]      col,
    output c2d_pkg::column_t               column
);

    c2d_pkg::line_word_t               line_mem [c2d_pkg::IMG_WIDTH];
    c2d_pkg::line_word_t               rd_data_reg;
    logic [c2d_pkg::PIX_W-1:0]         pix_reg;
    logic [c2d_pkg::COL_W-1:0]         addr_reg;

    function automatic logic [c2d_pkg::COL_W-1:0] addr_idx(input logic [c2d_pkg::COL_W-1:0] a);
        return a;
    endfunction

    // read on accept; data holds while the pipe is stalled
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rd_data_reg <= line_mem[addr_idx(col)];
            pix_reg     <= pixel;
            addr_reg    <= col;
        end
    end

    // write back the column moved up one line, new pixel on the newest line
    always_ff @(posedge clk)
    begin
        if (ctl.adv && ctl.s1_valid)
        begin
            line_mem[addr_idx(addr_reg)] <= {pix_reg, rd_data_reg[c2d_pkg::NLINES-1:1]};
        end
    end

    assign column = {pix_reg, rd_data_reg};

endmodule

// File: src/c2d_window.sv
// 5x5 window registers, shifted left as each column comes in
module c2d_window (
    input  logic                 clk,
    input  logic                 rst_n,
    input  c2d_pkg::pipe_ctl_t   ctl,
    input  c2d_pkg::column_t     column,
    output c2d_pkg::window_t     window
);

    c2d_pkg::window_t win_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (ctl.adv && ctl.s1_valid)
        begin
            for (int i = 0; i < c2d_pkg::KSIZE; i++)
            begin
                for (int j = 0; j < c2d_pkg::KSIZE - 1; j++)
                begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
                win_reg[i][c2d_pkg::KSIZE-1] <= column[i];
            end
        end
    end

    assign window = win_reg;

endmodule

// File: src/c2d_mac.sv
// 25 products, row sums and final sum over three register stages
module c2d_mac (
    input  logic                        clk,
    input  c2d_pkg::pipe_ctl_t          ctl,
    input  c2d_pkg::window_t            window,
    input  c2d_pkg::window_t            weights,
    output logic [c2d_pkg::SUM_W-1:0]   conv_sum
);

    logic [c2d_pkg::KSIZE-1:0][c2d_pkg::KSIZE-1:0][c2d_pkg::PROD_W-1:0] prod_next;
    logic [c2d_pkg::KSIZE-1:0][c2d_pkg::KSIZE-1:0][c2d_pkg::PROD_W-1:0] prod_reg;
    logic [c2d_pkg::KSIZE-1:0][c2d_pkg::RSUM_W-1:0]                     rsum_next;
    logic [c2d_pkg::KSIZE-1:0][c2d_pkg::RSUM_W-1:0]                     rsum_reg;
    logic [c2d_pkg::SUM_W-1:0]                                          sum_next;
    logic [c2d_pkg::SUM_W-1:0]                                          sum_reg;

    always_comb
    begin
        for (int i = 0; i < c2d_pkg::KSIZE; i++)
        begin
            for (int j = 0; j < c2d_pkg::KSIZE; j++)
            begin
                prod_next[i][j] = c2d_pkg::PROD_W'(window[i][j]) * c2d_pkg::PROD_W'(weights[i][j]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < c2d_pkg::KSIZE; i++)
        begin
            rsum_next[i] = '0;
            for (int j = 0; j < c2d_pkg::KSIZE; j++)
            begin
                rsum_next[i] = rsum_next[i] + c2d_pkg::RSUM_W'(prod_reg[i][j]);
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < c2d_pkg::KSIZE; i++)
        begin
            sum_next = sum_next + c2d_pkg::SUM_W'(rsum_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            prod_reg <= prod_next;
            rsum_reg <= rsum_next;
            sum_reg  <= sum_next;
        end
    end

    assign conv_sum = sum_reg;

endmodule

// File: src/conv2d_valid_5x5_stream.sv
// top level of the streaming 5x5 valid-mode convolution
//
//  channel   dir  kind          payload
//  pixels    in   valid/ready   pixel (8 bits, raster order)
//  results   out  valid/ready   conv_sum, out_row, out_col, last_of_frame
//  cfg       in   write only    cfg_we, cfg_index (3 bits), cfg_data (40 bits)
//
// one pixel item per cycle sustained while results are not stalled; accept to result
// passes line memory read, window, products, row sums, final sum / output register
// the line memory is read once and written once per item, at different columns,
// so its single read port sets the one-item-per-cycle figure
// a stall on results freezes the whole pipe; pixels.ready follows it directly
// reset clears counters, valid bits, window and kernel; line memory needs no clearing
module conv2d_valid_5x5_stream (
    input  logic                              clk,
    input  logic                              rst_n,
    c2d_pixel_if.sink                         pixels,
    c2d_result_if.source                      results,
    input  logic                              cfg_we,
    input  logic [c2d_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [c2d_pkg::KREG_W-1:0]        cfg_data
);

    // kernel rows, column 0 weight in the low byte
    logic [c2d_pkg::KSIZE-1:0][c2d_pkg::KREG_W-1:0] kernel_reg;

    // raster position of the next pixel
    logic [c2d_pkg::ROW_W-1:0] row_reg;
    logic [c2d_pkg::COL_W-1:0] col_reg;

    // stage valid bits: line read, window, products, row sums, output
    logic s1_valid_reg;
    logic w_valid_reg;
    logic p_valid_reg;
    logic r_valid_reg;
    logic out_valid_reg;

    // position metadata travelling alongside the data stages
    c2d_pkg::pos_meta_t meta_s1_reg;
    c2d_pkg::pos_meta_t meta_w_reg;
    c2d_pkg::pos_meta_t meta_p_reg;
    c2d_pkg::pos_meta_t meta_r_reg;
    c2d_pkg::pos_meta_t meta_out_reg;
    c2d_pkg::pos_meta_t meta_next;

    logic                       adv;
    logic                       accept;
    logic                       last_col;
    logic                       last_row;
    c2d_pkg::pipe_ctl_t         ctl;
    c2d_pkg::column_t           column;
    c2d_pkg::window_t           window;
    c2d_pkg::window_t           weights;
    logic [c2d_pkg::SUM_W-1:0]  conv_sum;

    // whole pipe moves unless a finished result is waiting and not taken
    assign adv    = !out_valid_reg || results.ready;
    assign accept = pixels.valid && adv;

    assign pixels.ready = adv;

    assign ctl.adv      = adv;
    assign ctl.load     = accept;
    assign ctl.s1_valid = s1_valid_reg;

    assign last_col = (col_reg == c2d_pkg::COL_W'(c2d_pkg::IMG_WIDTH - 1));
    assign last_row = (row_reg == c2d_pkg::ROW_W'(c2d_pkg::IMG_HEIGHT - 1));

    // result exists once four full lines and four columns are behind us
    always_comb
    begin
        meta_next.emit = (row_reg >= c2d_pkg::ROW_W'(c2d_pkg::NLINES))
                      && (col_reg >= c2d_pkg::COL_W'(c2d_pkg::NLINES));
        meta_next.row  = c2d_pkg::POS_W'(row_reg - c2d_pkg::ROW_W'(c2d_pkg::NLINES));
        meta_next.col  = c2d_pkg::POS_W'(col_reg - c2d_pkg::COL_W'(c2d_pkg::NLINES));
        meta_next.last = last_row && last_col;
    end

    // configuration: the user writes only while idle; the block does not enforce it, no interlock
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                c2d_pkg::REG_KERNEL_ROW0: kernel_reg[0] <= cfg_data;
                c2d_pkg::REG_KERNEL_ROW1: kernel_reg[1] <= cfg_data;
                c2d_pkg::REG_KERNEL_ROW2: kernel_reg[2] <= cfg_data;
                c2d_pkg::REG_KERNEL_ROW3: kernel_reg[3] <= cfg_data;
                c2d_pkg::REG_KERNEL_ROW4: kernel_reg[4] <= cfg_data;
                default: ;
            endcase
        end
    end

    // raster counters, wrap at the end of a line and of a frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // stage valid bits; warm-up items drop out after the line read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            w_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            r_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            w_valid_reg   <= s1_valid_reg && meta_s1_reg.emit;
            p_valid_reg   <= w_valid_reg;
            r_valid_reg   <= p_valid_reg;
            out_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (accept)
            begin
                meta_s1_reg <= meta_next;
            end
            meta_w_reg   <= meta_s1_reg;
            meta_p_reg   <= meta_w_reg;
            meta_r_reg   <= meta_p_reg;
            meta_out_reg <= meta_r_reg;
        end
    end

    c2d_line_buf u_line_buf (
        .clk    (clk),
        .ctl    (ctl),
        .pixel  (pixels.data.pixel),
        .col    (col_reg),
        .column (column)
    );

    c2d_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .column (column),
        .window (window)
    );

    // same bit layout: row i, column j at byte j of kernel row i
    assign weights = kernel_reg;

    c2d_mac u_mac (
        .clk      (clk),
        .ctl      (ctl),
        .window   (window),
        .weights  (weights),
        .conv_sum (conv_sum)
    );

    assign results.valid              = out_valid_reg;
    assign results.data.conv_sum      = conv_sum;
    assign results.data.out_row       = meta_out_reg.row;
    assign results.data.out_col       = meta_out_reg.col;
    assign results.data.last_of_frame = meta_out_reg.last;

endmodule

// File: src/c2d_checker.sv
// port-level checks of the convolution stream, bound to the top level
module c2d_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_ready,
    input  logic                              res_valid,
    input  logic                              res_ready,
    input  c2d_pkg::result_item_t             res_data
);

`include "conv2d_valid_5x5_stream_assert.svh"

    // a waiting result holds its value until taken
    `C2D_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data))

    // input is only held back by a stalled result
    `C2D_ASSERT_NOW(a_ready_stall, !in_ready, res_valid && !res_ready)

    // input is open whenever the output side is empty or drained
    `C2D_ASSERT_NOW(a_ready_open, !res_valid || res_ready, in_ready)

    // frame end only at the last output position
    `C2D_ASSERT_NOW(a_last_pos, res_valid && res_data.last_of_frame,
        res_data.out_row == c2d_pkg::POS_W'(c2d_pkg::IMG_HEIGHT - 1 - c2d_pkg::NLINES) &&
        res_data.out_col == c2d_pkg::POS_W'(c2d_pkg::IMG_WIDTH - 1 - c2d_pkg::NLINES))

endmodule

bind conv2d_valid_5x5_stream c2d_checker u_c2d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pixels.ready),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_data  (results.data)
);
